FILE: rtl/core/drt_pkg.sv
package drt_pkg;

  localparam int CHANNELS    = 8;
  localparam int TIME_BITS   = 32;
  localparam int WINDOW_BITS = 16;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  localparam logic [WINDOW_BITS-1:0] RESET_WINDOW = WINDOW_BITS'(50);

  localparam logic FUNC_BUTTON = 1'b0;
  localparam logic FUNC_SET    = 1'b1;

  typedef enum logic {
    REG_WINDOW   = 1'b0,
    REG_POLARITY = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [WINDOW_BITS-1:0] debounce_window;
    logic                   drive_high;
  } cfg_t;

endpackage

FILE: rtl/core/drt_regs.sv
module drt_regs
  import drt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  reg_index_t index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_window <= RESET_WINDOW;
      cfg.drive_high      <= 1'b0;
    end else if (wr) begin
      case (index)
        REG_WINDOW:   cfg.debounce_window <= pwdata[WINDOW_BITS-1:0];
        REG_POLARITY: cfg.drive_high      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_WINDOW:   prdata = DATA_BITS'(cfg.debounce_window);
      REG_POLARITY: prdata = DATA_BITS'(cfg.drive_high);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/drt_chan.sv
module drt_chan
  import drt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic                   ev,
  input  logic                   pressed,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [WINDOW_BITS-1:0] window,
  output logic                   tog
);

  logic [TIME_BITS-1:0] last;
  logic [TIME_BITS-1:0] elapsed;
  logic                 accept;

  assign elapsed = now - last;
  assign accept  = ev && (elapsed >= TIME_BITS'(window));
  assign tog     = accept && pressed;

  // advance the timestamp on every accepted press of a fired button beat, pressed or released
  always_ff @(posedge clk) begin
    if (rst) begin
      last <= '0;
    end else if (fire && accept) begin
      last <= now;
    end
  end

endmodule

FILE: rtl/core/debounced_relay_toggle.sv
// Debounced relay toggle: eight relay channels, each with its own press
// timestamp. A button beat (func 0) toggles every flagged channel whose last
// accepted press lies at least debounce_window ms back (modulo 2^32) and whose
// button still reads low; an accepted but released press only moves the
// timestamp. A set beat (func 1) loads all relay bits from new_mask. Each beat
// is captured in the input register and its result is registered in the
// result register when the beat advances; one beat is taken every cycle
// while result_stall does not hold the output, with the per-channel subtract
// and compare between the input and result registers. Configuration sits on
// an APB port at byte addresses 0 (window) and 4 (polarity); the user must
// write it only while no beat is in flight, which the block does not enforce.
module debounced_relay_toggle
  import drt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 func,
  input  logic [7:0]           event_mask,
  input  logic [7:0]           button_levels,
  input  logic [31:0]          now_ms,
  input  logic [7:0]           new_mask,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [7:0]           relay_state,
  output logic [7:0]           relay_drive,
  output logic [7:0]           led_drive,
  output logic [7:0]           toggled
);

  cfg_t cfg;

  logic                s1_valid;
  logic                s1_func;
  logic [CHANNELS-1:0] s1_event_mask;
  logic [CHANNELS-1:0] s1_button_levels;
  logic [TIME_BITS-1:0] s1_now;
  logic [CHANNELS-1:0] s1_new_mask;

  logic                load;
  logic                advance;
  logic                fire;
  logic [CHANNELS-1:0] tog_vec;
  logic [CHANNELS-1:0] tog_eff;
  logic [CHANNELS-1:0] relay_on;
  logic [CHANNELS-1:0] relay_on_next;

  drt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;
  assign load       = item_valid && !item_stall;
  assign fire       = advance && (s1_func == FUNC_BUTTON);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_func          <= func;
      s1_event_mask    <= event_mask[CHANNELS-1:0];
      s1_button_levels <= button_levels[CHANNELS-1:0];
      s1_now           <= TIME_BITS'(now_ms);
      s1_new_mask      <= new_mask[CHANNELS-1:0];
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    drt_chan u_chan (
      .clk     (clk),
      .rst     (rst),
      .fire    (fire),
      .ev      (s1_event_mask[g]),
      .pressed (!s1_button_levels[g]),
      .now     (s1_now),
      .window  (cfg.debounce_window),
      .tog     (tog_vec[g])
    );
  end

  assign tog_eff       = (s1_func == FUNC_SET) ? '0 : tog_vec;
  assign relay_on_next = (s1_func == FUNC_SET) ? s1_new_mask : (relay_on ^ tog_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_on <= '0;
    end else if (advance) begin
      relay_on <= relay_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      relay_state <= 8'(relay_on_next);
      led_drive   <= 8'(relay_on_next);
      relay_drive <= cfg.drive_high ? 8'(relay_on_next) : 8'(~relay_on_next);
      toggled     <= 8'(tog_eff);
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("stall raised with empty input register");

  a_toggle_within_events: assert property (@(posedge clk) disable iff (rst)
    advance |-> ((tog_eff & ~s1_event_mask) == '0))
    else $error("toggle on a channel without an event");

  a_button_update: assert property (@(posedge clk) disable iff (rst)
    fire |=> relay_on == $past(relay_on ^ tog_vec))
    else $error("relay state not updated by toggles");

  a_set_update: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_func == FUNC_SET) |=> relay_on == $past(s1_new_mask))
    else $error("set beat not loaded into relay state");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> relay_state == 8'(relay_on))
    else $error("result disagrees with relay state");
`endif

endmodule
